@@ rtl/core/hkd_pkg.sv @@
// ----------------------------------------------------------------------------
// hkd_pkg
// Shared constants and types of the heatmap keypoint decoder.
// ----------------------------------------------------------------------------
package hkd_pkg;

  localparam int unsigned MAX_KEYPOINTS = 70;
  localparam int unsigned MAX_MAP_SIDE  = 128;

  localparam int unsigned SIDE_W  = 8;   // map side register width
  localparam int unsigned CNT_W   = 7;   // column, row, map and found counters
  localparam int unsigned KP_W    = 7;
  localparam int unsigned THR_W   = 13;
  localparam int unsigned HEAT_W  = 16;
  localparam int unsigned BOX_W   = 12;
  localparam int unsigned PT_W    = 17;  // Q.4 pixel coordinate
  localparam int unsigned FRAC_W  = 4;

  // Scaled position: position * box size * 16
  localparam int unsigned NUM_W   = CNT_W + BOX_W + FRAC_W;
  localparam int unsigned STEP_W  = $clog2(NUM_W);

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = THR_W;

  localparam logic [CFG_ADDR_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KEYPOINTS  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD  = 2'd3;

  localparam logic [SIDE_W-1:0] MAP_WIDTH_RST  = 8'd46;
  localparam logic [SIDE_W-1:0] MAP_HEIGHT_RST = 8'd46;
  localparam logic [KP_W-1:0]   KEYPOINTS_RST  = 7'd70;
  localparam logic [THR_W-1:0]  THRESHOLD_RST  = 13'd410;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 88;

  // Effective (clamped) settings seen by the datapath
  typedef struct packed {
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic [SIDE_W-1:0] keypoints;
    logic [THR_W-1:0]  threshold;
  } hkd_cfg_t;

  // Everything known about a map when its last sample is taken
  typedef struct packed {
    logic [KP_W-1:0]   index;
    logic              found;
    logic [CNT_W-1:0]  count;
    logic              last;
    logic [CNT_W-1:0]  column;
    logic [CNT_W-1:0]  row;
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic [BOX_W-1:0]  box_x;
    logic [BOX_W-1:0]  box_y;
    logic [BOX_W-1:0]  box_w;
    logic [BOX_W-1:0]  box_h;
  } hkd_map_res_t;

endpackage

@@ rtl/core/hkd_divider.sv @@
// ----------------------------------------------------------------------------
// hkd_divider
// Restoring divider, one quotient bit per cycle, shared by both axes.
// ----------------------------------------------------------------------------
module hkd_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [hkd_pkg::NUM_W-1:0]    numerator,
  input  logic [hkd_pkg::SIDE_W-1:0]   divisor,
  output logic                         done,
  output logic [hkd_pkg::NUM_W-1:0]    quotient
);
  import hkd_pkg::*;

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [SIDE_W-1:0]   dvs;
  logic [SIDE_W-1:0]   rem;
  logic [SIDE_W:0]     trial;
  logic                fits;

  // remainder stays below the divisor, so one extra bit holds the shifted value
  assign trial = {rem, quotient[NUM_W-1]} - {1'b0, dvs};
  assign fits  = ~trial[SIDE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs      <= divisor;
      rem      <= '0;
      quotient <= numerator;
    end else if (busy) begin
      rem      <= fits ? trial[SIDE_W-1:0] : {rem[SIDE_W-2:0], quotient[NUM_W-1]};
      quotient <= {quotient[NUM_W-2:0], fits};
    end
  end

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) done |-> $past(busy);
  endproperty
  assert property (p_done_after_busy) else $error("divider done without a run");

  property p_step_bound;
    @(posedge clk) disable iff (rst) busy |-> (step < STEP_W'(NUM_W));
  endproperty
  assert property (p_step_bound) else $error("divider step out of range");

  property p_start_clears_done;
    @(posedge clk) disable iff (rst) start |=> !done;
  endproperty
  assert property (p_start_clears_done) else $error("divider finished too early");

endmodule

@@ rtl/core/hkd_peak_tracker.sv @@
// ----------------------------------------------------------------------------
// hkd_peak_tracker
// Scan counters, running peak, box latch and found count per frame.
// ----------------------------------------------------------------------------
module hkd_peak_tracker (
  input  logic                          clk,
  input  logic                          rst,
  input  hkd_pkg::hkd_cfg_t             cfg,
  input  logic                          take,
  input  logic signed [hkd_pkg::HEAT_W-1:0] heat_value,
  input  logic [hkd_pkg::BOX_W-1:0]     box_x,
  input  logic [hkd_pkg::BOX_W-1:0]     box_y,
  input  logic [hkd_pkg::BOX_W-1:0]     box_width,
  input  logic [hkd_pkg::BOX_W-1:0]     box_height,
  output logic                          res_valid,
  output hkd_pkg::hkd_map_res_t         res
);
  import hkd_pkg::*;

  logic [CNT_W-1:0]         column_counter;
  logic [CNT_W-1:0]         row_counter;
  logic [CNT_W-1:0]         map_counter;
  logic [CNT_W-1:0]         found_counter;
  logic signed [HEAT_W-1:0] peak_value;
  logic [CNT_W-1:0]         peak_column;
  logic [CNT_W-1:0]         peak_row;
  logic [4*BOX_W-1:0]       latched_box;

  logic [CNT_W-1:0]         col_inc, row_inc, map_inc;
  logic                     col_wrap, row_wrap, map_end, last;
  logic                     frame_start, map_start, replace, found;
  logic [4*BOX_W-1:0]       box_cur;
  logic signed [HEAT_W-1:0] peak_value_next;
  logic [CNT_W-1:0]         peak_column_next, peak_row_next;
  logic [CNT_W-1:0]         found_base, found_next;

  always_comb begin
    col_inc  = column_counter + 1'b1;
    row_inc  = row_counter + 1'b1;
    map_inc  = map_counter + 1'b1;
    col_wrap = ({1'b0, col_inc} >= cfg.width) || (col_inc == '0);
    row_wrap = ({1'b0, row_inc} >= cfg.height) || (row_inc == '0);
    map_end  = col_wrap && row_wrap;
    last     = ({1'b0, map_counter} + 1'b1) >= cfg.keypoints;

    map_start   = (column_counter == '0) && (row_counter == '0);
    frame_start = map_start && (map_counter == '0);
    box_cur     = frame_start ? {box_height, box_width, box_y, box_x} : latched_box;

    replace          = map_start || (heat_value > peak_value);
    peak_value_next  = replace ? heat_value : peak_value;
    peak_column_next = replace ? column_counter : peak_column;
    peak_row_next    = replace ? row_counter : peak_row;

    found      = $signed({peak_value_next[HEAT_W-1], peak_value_next})
               > $signed({{(HEAT_W + 1 - THR_W){1'b0}}, cfg.threshold});
    found_base = frame_start ? '0 : found_counter;
    found_next = found ? found_base + 1'b1 : found_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
      map_counter    <= '0;
      found_counter  <= '0;
      peak_value     <= '0;
      peak_column    <= '0;
      peak_row       <= '0;
      latched_box    <= '0;
      res_valid      <= 1'b0;
    end else begin
      res_valid <= take && map_end;
      if (take) begin
        column_counter <= col_wrap ? '0 : col_inc;
        if (col_wrap) begin
          row_counter <= row_wrap ? '0 : row_inc;
        end
        if (map_end) begin
          map_counter   <= last ? '0 : map_inc;
          found_counter <= found_next;
        end else begin
          found_counter <= found_base;
        end
        peak_value  <= peak_value_next;
        peak_column <= peak_column_next;
        peak_row    <= peak_row_next;
        latched_box <= box_cur;
      end
    end
  end

  // snapshot of the finished map
  always_ff @(posedge clk) begin
    if (take && map_end) begin
      res.index  <= map_counter;
      res.found  <= found;
      res.count  <= found_next;
      res.last   <= last;
      res.column <= peak_column_next;
      res.row    <= peak_row_next;
      res.width  <= cfg.width;
      res.height <= cfg.height;
      res.box_x  <= box_cur[BOX_W-1:0];
      res.box_y  <= box_cur[2*BOX_W-1:BOX_W];
      res.box_w  <= box_cur[3*BOX_W-1:2*BOX_W];
      res.box_h  <= box_cur[4*BOX_W-1:3*BOX_W];
    end
  end

  property p_col_in_range;
    @(posedge clk) disable iff (rst)
      $past(take) && !$past(rst) |-> ({1'b0, column_counter} < $past(cfg.width));
  endproperty
  assert property (p_col_in_range) else $error("column counter past map width");

  property p_result_on_wrap;
    @(posedge clk) disable iff (rst)
      res_valid |-> (column_counter == '0) && (row_counter == '0);
  endproperty
  assert property (p_result_on_wrap) else $error("map result without scan wrap");

  property p_count_bound;
    @(posedge clk) disable iff (rst) res_valid |-> (res.count <= {1'b0, res.index} + 1'b1);
  endproperty
  assert property (p_count_bound) else $error("found count exceeds maps seen");

endmodule

@@ rtl/core/heatmap_keypoint_decoder.sv @@
// ----------------------------------------------------------------------------
// heatmap_keypoint_decoder
// Per-map argmax over a heatmap stream, threshold test and mapping of the
// peak into the face box in Q.4 pixels.
//
//   channel   dir  transfer                     payload
//   s_axis    in   one heatmap sample           tdata: heat, box x/y/w/h
//   m_axis    out  one keypoint per map         tdata, tuser=found, tlast=frame
//   cfg       in   register write (cfg_we)      cfg_addr, cfg_wdata
//
// A sample that does not end a map does not stall the input. The sample
// that ends a map stalls it: a start, then x and y in turn in one shared
// restoring divider (one bit per cycle), then a load of the output register.
// The result may wait there for m_axis while the next map streams in; a result
// still waiting when the next map ends stretches that stall until it is taken.
// Reset is synchronous: it clears counters, peak, box latch and valid flags.
// ----------------------------------------------------------------------------
module heatmap_keypoint_decoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // heat_value[15:0], box_x[27:16], box_y[39:28], box_width[51:40],
  // box_height[63:52]
  input  logic [hkd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // keypoint_index[6:0], point_x[23:7], point_y[40:24], detected_count[47:41],
  // center_x[64:48], center_y[81:65], zero[87:82]
  output logic [hkd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // found[0]
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast,
  input  logic                               cfg_we,
  input  logic [hkd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [hkd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import hkd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIVX = 4'b0010,
    ST_DIVY = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [SIDE_W-1:0] map_width, map_height;
  logic [KP_W-1:0]   keypoints_used;
  logic [THR_W-1:0]  confidence_threshold;
  hkd_cfg_t          cfg;

  logic              take;
  logic              res_valid;
  hkd_map_res_t      res;

  logic              div_start, div_done, use_y;
  logic [NUM_W-1:0]  div_num, div_q;
  logic [SIDE_W-1:0] div_den;
  logic [CNT_W-1:0]  mul_pos;
  logic [BOX_W-1:0]  mul_size;
  logic [CNT_W+BOX_W-1:0] mul_prod;
  logic [PT_W-1:0]   qx;

  logic [PT_W-1:0]   point_x, point_y, center_x, center_y;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width            <= MAP_WIDTH_RST;
      map_height           <= MAP_HEIGHT_RST;
      keypoints_used       <= KEYPOINTS_RST;
      confidence_threshold <= THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAP_WIDTH:  map_width            <= cfg_wdata[SIDE_W-1:0];
        REG_MAP_HEIGHT: map_height           <= cfg_wdata[SIDE_W-1:0];
        REG_KEYPOINTS:  keypoints_used       <= cfg_wdata[KP_W-1:0];
        REG_THRESHOLD:  confidence_threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp zero up to one and large values down to the maximum
  always_comb begin
    cfg.width = (map_width == '0) ? SIDE_W'(1)
              : (map_width > SIDE_W'(MAX_MAP_SIDE)) ? SIDE_W'(MAX_MAP_SIDE) : map_width;
    cfg.height = (map_height == '0) ? SIDE_W'(1)
               : (map_height > SIDE_W'(MAX_MAP_SIDE)) ? SIDE_W'(MAX_MAP_SIDE) : map_height;
    cfg.keypoints = (keypoints_used == '0) ? SIDE_W'(1)
                  : ({1'b0, keypoints_used} > SIDE_W'(MAX_KEYPOINTS)) ? SIDE_W'(MAX_KEYPOINTS)
                  : {1'b0, keypoints_used};
    cfg.threshold = confidence_threshold;
  end

  // hold the input while a finished map is being scaled
  assign s_axis_tready = (state == ST_IDLE) && !res_valid;
  assign take          = s_axis_tvalid && s_axis_tready;

  hkd_peak_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .take       (take),
    .heat_value (s_axis_tdata[HEAT_W-1:0]),
    .box_x      (s_axis_tdata[HEAT_W+BOX_W-1:HEAT_W]),
    .box_y      (s_axis_tdata[HEAT_W+2*BOX_W-1:HEAT_W+BOX_W]),
    .box_width  (s_axis_tdata[HEAT_W+3*BOX_W-1:HEAT_W+2*BOX_W]),
    .box_height (s_axis_tdata[HEAT_W+4*BOX_W-1:HEAT_W+3*BOX_W]),
    .res_valid  (res_valid),
    .res        (res)
  );

  // operand select for the shared divider: x first, y once x is done
  assign use_y    = (state == ST_DIVX);
  assign mul_pos  = use_y ? res.row : res.column;
  assign mul_size = use_y ? res.box_h : res.box_w;
  assign mul_prod = mul_pos * mul_size;
  assign div_num  = {mul_prod, {FRAC_W{1'b0}}};
  assign div_den  = use_y ? res.height : res.width;

  assign div_start = ((state == ST_IDLE) && res_valid) || ((state == ST_DIVX) && div_done);

  hkd_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .numerator (div_num),
    .divisor   (div_den),
    .done      (div_done),
    .quotient  (div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (res_valid) state_next = ST_DIVX;
      ST_DIVX: if (div_done)  state_next = ST_DIVY;
      ST_DIVY: if (div_done)  state_next = ST_EMIT;
      ST_EMIT: if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DIVX) && div_done) begin
      qx <= div_q[PT_W-1:0];
    end
  end

  // y quotient stays in the divider until the next start
  always_comb begin
    point_x  = res.found ? ({1'b0, res.box_x, {FRAC_W{1'b0}}} + qx) : '0;
    point_y  = res.found ? ({1'b0, res.box_y, {FRAC_W{1'b0}}} + div_q[PT_W-1:0]) : '0;
    center_x = {1'b0, res.box_x, {FRAC_W{1'b0}}} + {2'b00, res.box_w, 3'b000};
    center_y = {1'b0, res.box_y, {FRAC_W{1'b0}}} + {2'b00, res.box_h, 3'b000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {{(OUT_DATA_W - 2*KP_W - 4*PT_W){1'b0}}, center_y, center_x,
                       res.count, point_y, point_x, res.index};
      m_axis_tuser <= res.found;
      m_axis_tlast <= res.last;
    end
  end

  property p_ready_only_idle;
    @(posedge clk) disable iff (rst) s_axis_tready |-> (state == ST_IDLE);
  endproperty
  assert property (p_ready_only_idle) else $error("input ready while busy");

  property p_done_in_div;
    @(posedge clk) disable iff (rst) div_done |-> (state == ST_DIVX) || (state == ST_DIVY);
  endproperty
  assert property (p_done_in_div) else $error("divider result outside a division state");

  property p_not_found_zero;
    @(posedge clk) disable iff (rst)
      m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[2*PT_W+KP_W-1:KP_W] == '0);
  endproperty
  assert property (p_not_found_zero) else $error("coordinates set on a missed keypoint");

  property p_result_into_idle;
    @(posedge clk) disable iff (rst) res_valid |-> (state == ST_IDLE);
  endproperty
  assert property (p_result_into_idle) else $error("map finished while scaling");

endmodule
